FILE: src/assert_macros.svh
// assertion macros shared by the rtl that checks itself
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on the rising clock edge
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on the rising clock edge
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/udivr_pkg.sv
// shared constants and controller/datapath interface types of the divider
// no dependencies
`timescale 1ns / 1ps

package udivr_pkg;

   // fixed port width of the operand and result fields
   localparam int FIELD_W = 64;
   // operand width in narrow mode
   localparam int NARROW_W = 32;
   // default wide operand width
   localparam int DEFAULT_MAX_WIDTH = 64;

   // commands from controller to datapath
   typedef struct packed {
      logic load;     // capture operands on an input transfer
      logic step;     // one shift-and-subtract iteration
      logic publish;  // move the finished result into the output register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic den_zero; // captured divisor is zero in the active width
      logic last;     // the current iteration is the final one
   } status_type;

endpackage

FILE: src/udivr_ctrl.sv
// controller of the divider: sequencing state machine and output valid
// depends on udivr_pkg
`timescale 1ns / 1ps

module udivr_ctrl
   import udivr_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_FIN  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free;

   // output register can take a result this cycle
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // commands
   always_comb begin
      cmd.load    = (state_ff == ST_IDLE) && req_valid;
      cmd.step    = (state_ff == ST_RUN) && !status.den_zero;
      cmd.publish = (state_ff == ST_FIN) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_RUN;
         end
         ST_RUN: begin
            if (status.den_zero || status.last) state_in = ST_FIN;
         end
         ST_FIN: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid: set on publish, cleared when the result transfers
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish)    rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: src/udivr_dpath.sv
// datapath of the divider: operand registers, shift-subtract unit, output register
// depends on udivr_pkg
`timescale 1ns / 1ps

module udivr_dpath
   import udivr_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic               clock,
   input  logic [FIELD_W-1:0] req_dividend,
   input  logic [FIELD_W-1:0] req_divisor,
   input  logic               req_wide_mode,
   input  cmd_type            cmd,
   output status_type         status,
   output logic [FIELD_W-1:0] rsp_quotient,
   output logic [FIELD_W-1:0] rsp_remainder,
   output logic               rsp_divide_by_zero
);

   localparam int CNT_W = $clog2(MAX_WIDTH + 1);
   localparam int IDX_W = $clog2(MAX_WIDTH);
   localparam logic [MAX_WIDTH-1:0] NARROW_MASK = MAX_WIDTH'({NARROW_W{1'b1}});

   logic [MAX_WIDTH-1:0] num_ff, num_in;
   logic [MAX_WIDTH-1:0] den_ff, den_in;
   logic [MAX_WIDTH-1:0] rem_ff, rem_in;
   logic [MAX_WIDTH-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 dz_ff, dz_in;
   logic [MAX_WIDTH-1:0] out_quo_ff, out_quo_in;
   logic [MAX_WIDTH-1:0] out_rem_ff, out_rem_in;
   logic                 out_dz_ff, out_dz_in;

   logic [MAX_WIDTH-1:0] op_mask;
   logic [MAX_WIDTH-1:0] num_masked, den_masked;
   logic [IDX_W-1:0]     bit_idx;
   logic [MAX_WIDTH:0]   trial;
   logic [MAX_WIDTH:0]   den_ext;
   logic [MAX_WIDTH:0]   diff;
   logic                 ge;

   // operand masking to the active width
   assign op_mask    = req_wide_mode ? {MAX_WIDTH{1'b1}} : NARROW_MASK;
   assign num_masked = req_dividend[MAX_WIDTH-1:0] & op_mask;
   assign den_masked = req_divisor[MAX_WIDTH-1:0] & op_mask;

   // one restoring iteration: bring down the next dividend bit, trial subtract
   assign bit_idx = IDX_W'(cnt_ff - 1'b1);
   assign trial   = {rem_ff, num_ff[bit_idx]};
   assign den_ext = {1'b0, den_ff};
   assign diff    = trial - den_ext;
   assign ge      = (trial >= den_ext);

   // working registers
   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      dz_in  = dz_ff;
      if (cmd.load) begin
         num_in = num_masked;
         den_in = den_masked;
         rem_in = '0;
         quo_in = '0;
         cnt_in = req_wide_mode ? CNT_W'(MAX_WIDTH) : CNT_W'(NARROW_W);
         dz_in  = (den_masked == '0);
      end else if (cmd.step) begin
         rem_in = ge ? diff[MAX_WIDTH-1:0] : trial[MAX_WIDTH-1:0];
         quo_in = {quo_ff[MAX_WIDTH-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // output register, loaded on publish
   always_comb begin
      out_quo_in = out_quo_ff;
      out_rem_in = out_rem_ff;
      out_dz_in  = out_dz_ff;
      if (cmd.publish) begin
         out_quo_in = dz_ff ? '0 : quo_ff;
         out_rem_in = dz_ff ? num_ff : rem_ff;
         out_dz_in  = dz_ff;
      end
   end

   always_ff @(posedge clock) begin
      num_ff     <= num_in;
      den_ff     <= den_in;
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      cnt_ff     <= cnt_in;
      dz_ff      <= dz_in;
      out_quo_ff <= out_quo_in;
      out_rem_ff <= out_rem_in;
      out_dz_ff  <= out_dz_in;
   end

   always_comb begin
      status.den_zero = dz_ff;
      status.last     = (cnt_ff == CNT_W'(1));
   end

   assign rsp_quotient       = FIELD_W'(out_quo_ff);
   assign rsp_remainder      = FIELD_W'(out_rem_ff);
   assign rsp_divide_by_zero = out_dz_ff;

endmodule

FILE: src/unsigned_divider_with_remainder_top.sv
// channel   direction  fields
// req_      in         dividend[63:0] divisor[63:0] wide_mode
// rsp_      out        quotient[63:0] remainder[63:0] divide_by_zero
//
// radix-2 restoring divider, one quotient bit per cycle from the shift-subtract unit
// an item is loaded, iterated once per bit of its active width and published; a zero divisor skips the iterations
// the output register holds one result, so a new transfer is taken while it waits
// a result stalled at rsp_ holds the controller in its final state until it moves
// reset is synchronous and clears only the controller state and rsp_valid
// depends on udivr_pkg, udivr_ctrl, udivr_dpath and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module unsigned_divider_with_remainder_top
   import udivr_pkg::*;
#(
   parameter int MAX_WIDTH = DEFAULT_MAX_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FIELD_W-1:0] req_dividend,
   input  logic [FIELD_W-1:0] req_divisor,
   input  logic               req_wide_mode,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [FIELD_W-1:0] rsp_quotient,
   output logic [FIELD_W-1:0] rsp_remainder,
   output logic               rsp_divide_by_zero
);

   cmd_type    cmd;
   status_type status;

   // sequencing
   udivr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and result storage
   udivr_dpath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dpath (
      .clock              (clock),
      .req_dividend       (req_dividend),
      .req_divisor        (req_divisor),
      .req_wide_mode      (req_wide_mode),
      .cmd                (cmd),
      .status             (status),
      .rsp_quotient       (rsp_quotient),
      .rsp_remainder      (rsp_remainder),
      .rsp_divide_by_zero (rsp_divide_by_zero)
   );

   // checks on controller/datapath cooperation
   `ASSERT_IMPL(a_load_alone, clock, reset, req_valid && !req_stall, !cmd.step && !cmd.publish, "input transfer overlaps iteration or publish")
   `ASSERT_IMPL(a_publish_free, clock, reset, cmd.publish, !rsp_valid || !rsp_stall, "publish overwrites a pending result")
   `ASSERT_NEXT(a_publish_valid, clock, reset, cmd.publish, rsp_valid, "published result not presented")
   `ASSERT_IMPL(a_dz_quotient, clock, reset, rsp_valid && rsp_divide_by_zero, rsp_quotient == '0, "nonzero quotient on zero divisor")

endmodule

FILE: tb/unsigned_divider_with_remainder_top_tb.sv
// self-checking testbench for the unsigned divider with remainder, narrow and wide modes
// predicts quotient, remainder and divide-by-zero flag per transfer and checks them in order
// depends on udivr_pkg and unsigned_divider_with_remainder_top
`timescale 1ns / 1ps

module unsigned_divider_with_remainder_top_tb;
   import udivr_pkg::*;

   localparam int DIV_MAX_WIDTH = DEFAULT_MAX_WIDTH;
   localparam int RESET_CYCLES  = 10;
   localparam int RANDOM_ITEMS  = 1250;
   localparam int HOLD_CYCLES   = 400;
   localparam int DRAIN_CYCLES  = 2 * DIV_MAX_WIDTH + 20;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int PRINT_LIMIT   = 100;

   typedef logic [FIELD_W-1:0] word_type;

   typedef struct packed {
      word_type quotient;
      word_type remainder;
      logic     divide_by_zero;
   } div_result_type;

   // expected results in transfer order, compared against the rsp_ channel
   class division_scoreboard;
      div_result_type pending_divisions[$];
      int mismatch_count = 0;

      // floor division on the active width, zero divisor flagged instead of trapping
      function div_result_type divide_operands(word_type dividend, word_type divisor,
                                               logic wide);
         div_result_type res;
         word_type mask;
         word_type num;
         word_type den;
         mask = {FIELD_W{1'b1}} >> (FIELD_W - (wide ? DIV_MAX_WIDTH : NARROW_W));
         num  = dividend & mask;
         den  = divisor & mask;
         if (den == '0) begin
            res.quotient       = '0;
            res.remainder      = num;
            res.divide_by_zero = 1'b1;
         end else begin
            res.quotient       = (num / den) & mask;
            res.remainder      = (num % den) & mask;
            res.divide_by_zero = 1'b0;
         end
         return res;
      endfunction

      function void note_request(word_type dividend, word_type divisor, logic wide);
         pending_divisions.push_back(divide_operands(dividend, divisor, wide));
      endfunction

      task report_mismatch(string what);
         if (mismatch_count < PRINT_LIMIT)
            $display("mismatch: %s", what);
         mismatch_count++;
      endtask

      task check_response(word_type quotient, word_type remainder, logic divide_by_zero);
         div_result_type want;
         if (pending_divisions.size() == 0) begin
            report_mismatch($sformatf("result with none pending: q=%h r=%h dz=%b",
                                      quotient, remainder, divide_by_zero));
            return;
         end
         want = pending_divisions.pop_front();
         if (quotient !== want.quotient)
            report_mismatch($sformatf("quotient %h, predicted %h", quotient, want.quotient));
         if (remainder !== want.remainder)
            report_mismatch($sformatf("remainder %h, predicted %h",
                                      remainder, want.remainder));
         if (divide_by_zero !== want.divide_by_zero)
            report_mismatch($sformatf("divide_by_zero %b, predicted %b",
                                      divide_by_zero, want.divide_by_zero));
      endtask

      function int outstanding();
         return pending_divisions.size();
      endfunction
   endclass

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_stall;
   word_type req_dividend = '0;
   word_type req_divisor = '0;
   logic     req_wide_mode = 1'b0;
   logic     rsp_valid;
   logic     rsp_stall = 1'b0;
   word_type rsp_quotient;
   word_type rsp_remainder;
   logic     rsp_divide_by_zero;

   division_scoreboard sb = new();
   int unsigned cycle_count = 0;
   bit hold_off_req = 1'b0;
   bit sender_burst = 1'b0;

   unsigned_divider_with_remainder_top #(
      .MAX_WIDTH(DIV_MAX_WIDTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_dividend      (req_dividend),
      .req_divisor       (req_divisor),
      .req_wide_mode     (req_wide_mode),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_quotient      (rsp_quotient),
      .rsp_remainder     (rsp_remainder),
      .rsp_divide_by_zero(rsp_divide_by_zero)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("FAIL");
      $finish;
   end

   // idle run length: mostly none or short, now and then long
   function automatic int pick_idle_length();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      else if (roll < 85)
         return $urandom_range(1, 3);
      else if (roll < 97)
         return $urandom_range(4, 12);
      else
         return $urandom_range(20, 60);
   endfunction

   // random operand of varied magnitude
   function automatic word_type random_operand();
      word_type v;
      v = {$urandom, $urandom};
      if ($urandom_range(0, 2) == 0)
         v = v >> $urandom_range(1, FIELD_W - 1);
      return v;
   endfunction

   // offer one item after a random gap, none in a sender burst, and hold it until the transfer
   task automatic send_item(word_type dividend, word_type divisor, logic wide);
      int gap;
      gap = sender_burst ? 0 : pick_idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_dividend  <= dividend;
      req_divisor   <= divisor;
      req_wide_mode <= wide;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(dividend, divisor, wide);
   endtask

   // result side: check every transfer, stall in random runs, one long hold-off on request
   initial begin
      int   hold_left;
      int   stall_left;
      int   free_left;
      logic stall_next;
      hold_left  = 0;
      stall_left = 0;
      free_left  = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
            sb.check_response(rsp_quotient, rsp_remainder, rsp_divide_by_zero);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (free_left > 0) begin
            free_left--;
            stall_next = 1'b0;
         end else begin
            stall_left = pick_idle_length();
            free_left  = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(0, 16);
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   // stimulus and end of run
   initial begin
      word_type dividend;
      word_type divisor;
      logic     wide;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // extremes, zero divisors, ignored upper bits, small dividends, power-of-two divisors
      send_item(64'h0, 64'h1, 1'b0);
      send_item(64'h0, 64'h1, 1'b1);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h1, 1'b1);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFE, 1'b1);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001, 1'b1);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h3, 1'b1);
      send_item(64'h8000_0000_0000_0000, 64'h3, 1'b1);
      send_item(64'h0000_0000_FFFF_FFFF, 64'h1, 1'b0);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0000_FFFF_FFFF, 1'b0);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h0000_0001_0000_0001, 1'b0);
      send_item(64'h1234_5678_9ABC_DEF0, 64'h0, 1'b1);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 1'b0);
      send_item(64'hDEAD_BEEF_1234_5678, 64'hFFFF_FFFF_0000_0000, 1'b0);
      send_item(64'hDEAD_BEEF_1234_5678, 64'hFFFF_FFFF_0000_0000, 1'b1);
      send_item(64'h5, 64'h7, 1'b1);
      send_item(64'h1234, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      send_item(64'hFFFF_0000_0000_0005, 64'h0000_0000_8000_0000, 1'b0);
      send_item(64'hFFFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, 1'b1);
      send_item(64'h8000_0000_0000_0001, 64'h2, 1'b1);
      send_item(64'h0000_0000_FFFF_FFFF, 64'h0000_0000_8000_0000, 1'b0);
      send_item(64'h0000_0000_0000_ABCD, 64'h10, 1'b0);
      send_item(64'h0000_0000_7FFF_FFFF, 64'h0001_0000, 1'b0);

      // random operands, biased toward the interesting divisor classes
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 400)
            hold_off_req = 1'b1;
         if (i == 800) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (sb.outstanding() != 0);
         end
         if (i % 100 == 0)
            sender_burst = ($urandom_range(0, 3) == 0);
         wide     = 1'($urandom_range(0, 1));
         dividend = random_operand();
         case ($urandom_range(0, 9))
            0, 1, 2: divisor = random_operand();
            3: divisor = word_type'($urandom_range(1, 255));
            4: divisor = word_type'(1)
                         << $urandom_range(0, (wide ? DIV_MAX_WIDTH : NARROW_W) - 1);
            5: begin
               divisor  = random_operand();
               dividend = divisor - word_type'($urandom_range(0, 2));
            end
            6: begin
               divisor  = random_operand();
               dividend = (divisor == '0) ? '0 : dividend % divisor;
            end
            7: divisor = '0;
            8: divisor = dividend >> $urandom_range(0, 8);
            default: divisor = {$urandom, $urandom};
         endcase
         // garbage in the ignored upper halves
         if (!wide && $urandom_range(0, 1) == 1) begin
            dividend[FIELD_W-1:NARROW_W] = $urandom;
            divisor[FIELD_W-1:NARROW_W]  = $urandom;
         end
         send_item(dividend, divisor, wide);
      end
      req_valid <= 1'b0;

      while (sb.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatch_count == 0 && sb.outstanding() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
